// ----- design/nmea_rmc_position_parser_assert.svh -----
// Assertion macros for the RMC position parser checker.
`ifndef NMEA_RMC_POSITION_PARSER_ASSERT_SVH
`define NMEA_RMC_POSITION_PARSER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define RMC_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: implication failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define RMC_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication failed");

`endif

// ----- design/rmc_pkg.sv -----
// Types, constants and widths shared by the RMC position parser modules.
package rmc_pkg;

  localparam int unsigned MAX_SENTENCE_DEF = 128;
  localparam int unsigned QUEUE_DEPTH      = 2;

  localparam logic [7:0] ASCII_COMMA = 8'h2C;
  localparam logic [7:0] ASCII_DOT   = 8'h2E;
  localparam logic [7:0] ASCII_A     = 8'h41;
  localparam logic [7:0] ASCII_ZERO  = 8'h30;

  localparam int unsigned CC_W   = 4;
  localparam int unsigned DC_W   = 3;
  localparam int unsigned SEG_W  = 32;
  localparam int unsigned LEN_W  = 7;
  localparam int unsigned CHAR_W = 9;

  localparam logic [CC_W-1:0]  COMMA_MAX = 4'd8;
  localparam logic [DC_W-1:0]  DOT_MAX   = 3'd5;
  localparam logic [LEN_W-1:0] LEN_MAX   = 7'd127;

  // comma and dot positions that trigger a capture
  localparam logic [CC_W-1:0] COMMA_STATUS   = 4'd1;
  localparam logic [CC_W-1:0] COMMA_LAT_FRAC = 4'd3;
  localparam logic [CC_W-1:0] COMMA_LON_FRAC = 4'd5;
  localparam logic [DC_W-1:0] DOT_LAT        = 3'd1;
  localparam logic [DC_W-1:0] DOT_LON        = 3'd2;
  localparam logic [DC_W-1:0] DOT_SPEED      = 3'd3;
  localparam logic [DC_W-1:0] DOT_COURSE     = 3'd4;

  localparam logic [LEN_W-1:0] LAT_MIN_LEN  = 7'd4;
  localparam logic [LEN_W-1:0] LON_MIN_LEN  = 7'd5;
  localparam logic [LEN_W-1:0] FRAC_MIN_LEN = 7'd4;

  // speed = knots * 185 / 100; above the limit the result exceeds 16 bits
  localparam int unsigned PROD_W          = 23;
  localparam int unsigned RECIP_W         = 26;
  localparam int unsigned QUOT_PROD_W     = PROD_W + RECIP_W;
  localparam int unsigned SPEED_NUM       = 185;
  localparam int unsigned SPEED_SAT_LIMIT = 35424;
  localparam int unsigned DIV100_RECIP    = 42949673;
  localparam int unsigned DIV100_SHIFT    = 32;

  typedef enum logic [1:0] {
    KIND_COMMA,
    KIND_DOT,
    KIND_CHAR
  } rmc_kind_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       end_of_sentence;
  } rmc_in_t;

  typedef struct packed {
    logic        fix_valid;
    logic [6:0]  lat_degrees;
    logic [6:0]  lat_minutes;
    logic [31:0] lat_fraction;
    logic [9:0]  lon_degrees;
    logic [6:0]  lon_minutes;
    logic [31:0] lon_fraction;
    logic [15:0] ground_speed;
    logic [15:0] course_heading;
  } rmc_out_t;

  // classified byte handed from front to back
  typedef struct packed {
    rmc_kind_e         kind;
    logic              is_a;
    logic [CHAR_W-1:0] char_value;
    logic              parse;
    logic              last;
  } rmc_word_t;

endpackage

// ----- design/nmea_rmc_position_parser.sv -----
// Result path: the last byte of a sentence is written to the word queue, then sets the emit flag in the back end.
// Throughput: one byte per cycle while the back end is not stalled by a full result register.
// A two-word queue and a result register let input and output stall independently.
// Reset (rst_ni low, asynchronous) clears all counters and held fields to zero at once.
// Top level: RMC sentence parser, front classifier, word queue and back end.
module nmea_rmc_position_parser #(
  parameter int unsigned MAX_SENTENCE = rmc_pkg::MAX_SENTENCE_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rmc_pkg::rmc_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rmc_pkg::rmc_out_t out_data_o
);

  logic               fw_valid, fw_ready;
  rmc_pkg::rmc_word_t fw_word;
  logic               bw_valid, bw_ready;
  rmc_pkg::rmc_word_t bw_word;

  rmc_front #(
    .MAX_SENTENCE(MAX_SENTENCE)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .word_valid_o (fw_valid),
    .word_ready_i (fw_ready),
    .word_o       (fw_word)
  );

  rmc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fw_valid),
    .push_ready_o (fw_ready),
    .push_word_i  (fw_word),
    .pop_valid_o  (bw_valid),
    .pop_ready_i  (bw_ready),
    .pop_word_o   (bw_word)
  );

  rmc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .word_valid_i (bw_valid),
    .word_ready_o (bw_ready),
    .word_i       (bw_word),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

// ----- design/rmc_front.sv -----
// Front end: byte classification and per-sentence position counting.
module rmc_front #(
  parameter int unsigned MAX_SENTENCE = rmc_pkg::MAX_SENTENCE_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  rmc_pkg::rmc_in_t in_data_i,
  output logic             word_valid_o,
  input  logic             word_ready_i,
  output rmc_pkg::rmc_word_t word_o
);

  localparam int unsigned POS_W = $clog2(MAX_SENTENCE + 1);

  logic [POS_W-1:0] pos_q, pos_d;
  logic             parse;
  logic             accept;

  assign parse        = (pos_q < POS_W'(MAX_SENTENCE));
  assign in_ready_o   = word_ready_i;
  assign word_valid_o = in_valid_i;
  assign accept       = in_valid_i & word_ready_i;

  always_comb begin
    word_o.kind = rmc_pkg::KIND_CHAR;
    if (in_data_i.rx_byte == rmc_pkg::ASCII_COMMA) begin
      word_o.kind = rmc_pkg::KIND_COMMA;
    end else if (in_data_i.rx_byte == rmc_pkg::ASCII_DOT) begin
      word_o.kind = rmc_pkg::KIND_DOT;
    end
    word_o.is_a       = (in_data_i.rx_byte == rmc_pkg::ASCII_A);
    // 9-bit two's complement of byte minus '0'
    word_o.char_value = {1'b0, in_data_i.rx_byte} - {1'b0, rmc_pkg::ASCII_ZERO};
    word_o.parse      = parse;
    word_o.last       = in_data_i.end_of_sentence;
  end

  always_comb begin
    pos_d = pos_q;
    if (accept) begin
      if (in_data_i.end_of_sentence) begin
        pos_d = '0;
      end else if (parse) begin
        pos_d = pos_q + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

// ----- design/rmc_queue.sv -----
// Short word queue between the front and the back of the parser.
module rmc_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  rmc_pkg::rmc_word_t push_word_i,
  output logic               pop_valid_o,
  input  logic               pop_ready_i,
  output rmc_pkg::rmc_word_t pop_word_o
);

  localparam int unsigned DEPTH = rmc_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  rmc_pkg::rmc_word_t entry_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               push, pop;

  assign push_ready_o = (count_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_word_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ----- design/rmc_back.sv -----
// Back end: segment accumulation, field capture and result register.
module rmc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               word_valid_i,
  output logic               word_ready_o,
  input  rmc_pkg::rmc_word_t word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rmc_pkg::rmc_out_t  out_data_o
);

  localparam int unsigned CC_W   = rmc_pkg::CC_W;
  localparam int unsigned DC_W   = rmc_pkg::DC_W;
  localparam int unsigned SEG_W  = rmc_pkg::SEG_W;
  localparam int unsigned LEN_W  = rmc_pkg::LEN_W;
  localparam int unsigned CHAR_W = rmc_pkg::CHAR_W;
  localparam int unsigned PROD_W = rmc_pkg::PROD_W;
  localparam int unsigned QP_W   = rmc_pkg::QUOT_PROD_W;

  // per-sentence state
  logic [CC_W-1:0]  cc_q, cc_d;
  logic [DC_W-1:0]  dc_q, dc_d;
  logic [SEG_W-1:0] seg_q, seg_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [6:0]       f2_q, f2_d;
  logic [9:0]       f3_q, f3_d;
  logic [6:0]       t22_q, t22_d;
  logic [6:0]       t23_q, t23_d;
  logic             pend_q, pend_d;

  // held captures
  logic              fix_q, fix_d;
  logic [6:0]        lat_deg_q, lat_deg_d;
  logic [6:0]        lat_min_q, lat_min_d;
  logic [31:0]       lat_frac_q, lat_frac_d;
  logic [9:0]        lon_deg_q, lon_deg_d;
  logic [6:0]        lon_min_q, lon_min_d;
  logic [31:0]       lon_frac_q, lon_frac_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic              sat_q, sat_d;
  logic [15:0]       course_q, course_d;

  // result handoff
  logic              emit_q, emit_d;
  logic              out_valid_q, out_valid_d;
  rmc_pkg::rmc_out_t out_q;
  rmc_pkg::rmc_out_t result;

  logic              load, take;
  logic [SEG_W-1:0]  char32;
  logic [QP_W-1:0]   quot_prod;
  logic [15:0]       speed;

  assign load         = emit_q & (!out_valid_q | out_ready_i);
  assign word_ready_o = !emit_q | load;
  assign take         = word_valid_i & word_ready_o;
  assign char32       = {{(SEG_W - CHAR_W){word_i.char_value[CHAR_W-1]}}, word_i.char_value};

  // divide by 100 through the scaled reciprocal
  assign quot_prod = QP_W'(prod_q) * QP_W'(rmc_pkg::DIV100_RECIP);
  assign speed     = sat_q ? 16'hFFFF : quot_prod[rmc_pkg::DIV100_SHIFT +: 16];

  always_comb begin
    result.fix_valid      = fix_q;
    result.lat_degrees    = lat_deg_q;
    result.lat_minutes    = lat_min_q;
    result.lat_fraction   = lat_frac_q;
    result.lon_degrees    = lon_deg_q;
    result.lon_minutes    = lon_min_q;
    result.lon_fraction   = lon_frac_q;
    result.ground_speed   = speed;
    result.course_heading = course_q;
  end

  always_comb begin
    cc_d       = cc_q;
    dc_d       = dc_q;
    seg_d      = seg_q;
    len_d      = len_q;
    f2_d       = f2_q;
    f3_d       = f3_q;
    t22_d      = t22_q;
    t23_d      = t23_q;
    pend_d     = pend_q;
    fix_d      = fix_q;
    lat_deg_d  = lat_deg_q;
    lat_min_d  = lat_min_q;
    lat_frac_d = lat_frac_q;
    lon_deg_d  = lon_deg_q;
    lon_min_d  = lon_min_q;
    lon_frac_d = lon_frac_q;
    prod_d     = prod_q;
    sat_d      = sat_q;
    course_d   = course_q;

    if (take && word_i.parse) begin
      // the byte after the status comma decides the fix
      if (pend_q) begin
        fix_d  = word_i.is_a;
        pend_d = 1'b0;
      end
      case (word_i.kind)
        rmc_pkg::KIND_COMMA: begin
          if (cc_q == rmc_pkg::COMMA_STATUS) begin
            pend_d = 1'b1;
          end
          if (cc_q == rmc_pkg::COMMA_LAT_FRAC && len_q >= rmc_pkg::FRAC_MIN_LEN) begin
            lat_frac_d = seg_q;
          end
          if (cc_q == rmc_pkg::COMMA_LON_FRAC && len_q >= rmc_pkg::FRAC_MIN_LEN) begin
            lon_frac_d = seg_q;
          end
          if (cc_q < rmc_pkg::COMMA_MAX) begin
            cc_d = cc_q + CC_W'(1);
          end
          seg_d = '0;
          len_d = '0;
          f2_d  = '0;
          f3_d  = '0;
          t22_d = '0;
          t23_d = '0;
        end
        rmc_pkg::KIND_DOT: begin
          if (dc_q == rmc_pkg::DOT_LAT && len_q >= rmc_pkg::LAT_MIN_LEN) begin
            lat_deg_d = f2_q;
            lat_min_d = t22_q;
          end
          if (dc_q == rmc_pkg::DOT_LON && len_q >= rmc_pkg::LON_MIN_LEN) begin
            lon_deg_d = f3_q;
            lon_min_d = t23_q;
          end
          if (dc_q == rmc_pkg::DOT_SPEED) begin
            sat_d  = (seg_q > SEG_W'(rmc_pkg::SPEED_SAT_LIMIT));
            prod_d = PROD_W'(seg_q[15:0]) * PROD_W'(rmc_pkg::SPEED_NUM);
          end
          if (dc_q == rmc_pkg::DOT_COURSE) begin
            course_d = seg_q[15:0];
          end
          if (dc_q < rmc_pkg::DOT_MAX) begin
            dc_d = dc_q + DC_W'(1);
          end
          seg_d = '0;
          len_d = '0;
          f2_d  = '0;
          f3_d  = '0;
          t22_d = '0;
          t23_d = '0;
        end
        rmc_pkg::KIND_CHAR: begin
          seg_d = seg_q * SEG_W'(10) + char32;
          if (len_q < LEN_W'(2)) begin
            f2_d = f2_q * 7'd10 + char32[6:0];
          end
          if (len_q < LEN_W'(3)) begin
            f3_d = f3_q * 10'd10 + char32[9:0];
          end
          if (len_q == LEN_W'(2) || len_q == LEN_W'(3)) begin
            t22_d = t22_q * 7'd10 + char32[6:0];
          end
          if (len_q == LEN_W'(3) || len_q == LEN_W'(4)) begin
            t23_d = t23_q * 7'd10 + char32[6:0];
          end
          if (len_q < rmc_pkg::LEN_MAX) begin
            len_d = len_q + LEN_W'(1);
          end
        end
        default: begin
        end
      endcase
    end

    if (take && word_i.last) begin
      // status never seen before the end: drop the fix
      if (pend_d) begin
        fix_d = 1'b0;
      end
      cc_d   = '0;
      dc_d   = '0;
      pend_d = 1'b0;
      seg_d  = '0;
      len_d  = '0;
      f2_d   = '0;
      f3_d   = '0;
      t22_d  = '0;
      t23_d  = '0;
    end
  end

  always_comb begin
    emit_d = emit_q;
    if (take) begin
      emit_d = word_i.last;
    end else if (load) begin
      emit_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cc_q        <= '0;
      dc_q        <= '0;
      seg_q       <= '0;
      len_q       <= '0;
      f2_q        <= '0;
      f3_q        <= '0;
      t22_q       <= '0;
      t23_q       <= '0;
      pend_q      <= 1'b0;
      fix_q       <= 1'b0;
      lat_deg_q   <= '0;
      lat_min_q   <= '0;
      lat_frac_q  <= '0;
      lon_deg_q   <= '0;
      lon_min_q   <= '0;
      lon_frac_q  <= '0;
      prod_q      <= '0;
      sat_q       <= 1'b0;
      course_q    <= '0;
      emit_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cc_q        <= cc_d;
      dc_q        <= dc_d;
      seg_q       <= seg_d;
      len_q       <= len_d;
      f2_q        <= f2_d;
      f3_q        <= f3_d;
      t22_q       <= t22_d;
      t23_q       <= t23_d;
      pend_q      <= pend_d;
      fix_q       <= fix_d;
      lat_deg_q   <= lat_deg_d;
      lat_min_q   <= lat_min_d;
      lat_frac_q  <= lat_frac_d;
      lon_deg_q   <= lon_deg_d;
      lon_min_q   <= lon_min_d;
      lon_frac_q  <= lon_frac_d;
      prod_q      <= prod_d;
      sat_q       <= sat_d;
      course_q    <= course_d;
      emit_q      <= emit_d;
      out_valid_q <= out_valid_d;
    end
  end

  // sample the held fields once the emit flag is set and the result register is free
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- design/rmc_checker.sv -----
// Port-level checker for the RMC position parser, bound to the top level.
`include "nmea_rmc_position_parser_assert.svh"

module rmc_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input rmc_pkg::rmc_in_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input rmc_pkg::rmc_out_t out_data_o
);

  // sentences accepted but not yet delivered
  logic [2:0] open_q;
  logic       eos_acc, out_acc;

  assign eos_acc = in_valid_i & in_ready_o & in_data_i.end_of_sentence;
  assign out_acc = out_valid_o & out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else begin
      open_q <= open_q + {2'b00, eos_acc} - {2'b00, out_acc};
    end
  end

  `RMC_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))
  `RMC_ASSERT_IMP(a_out_needs_sentence, out_valid_o, open_q != 3'd0)
  `RMC_ASSERT_IMP(a_open_bounded, 1'b1, open_q <= 3'd4)
  `RMC_ASSERT_NXT(a_ready_when_drained, !out_valid_o && in_ready_o, in_ready_o)

endmodule

bind nmea_rmc_position_parser rmc_checker u_rmc_checker (.*);
